@@ hw/rtl/kerr_pkg.sv @@
package kerr_pkg;

   localparam int unsigned KEY_COUNT_DEFAULT   = 16;
   localparam int unsigned STORE_DEPTH_DEFAULT = 16384;

   localparam int unsigned KEY_W = 16;
   localparam int unsigned CNT_W = 15;

   localparam logic [CNT_W-1:0] RECORD_LIMIT_RESET = 15'd10000;

   typedef enum logic [1:0] {
      CMD_TICK         = 2'd0,
      CMD_RECORD_START = 2'd1,
      CMD_RECORD_STOP  = 2'd2,
      CMD_PLAY_START   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_RECORD = 3'b010,
      MODE_PLAY   = 3'b100
   } mode_type;

   typedef struct packed {
      logic [KEY_W-1:0] pressed;
      logic [KEY_W-1:0] pressed_edges;
      logic [KEY_W-1:0] released_edges;
      logic             playing;
      logic             recording;
      logic [CNT_W-1:0] frames_stored;
   } result_type;

endpackage

@@ hw/rtl/key_edge_record_replay.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_command, req_keys_down
// rsp      out        rsp_valid/rsp_ready  pressed, edges, mode flags, frames_stored
// csr      in         csr_wr_en            csr_wr_data (record_limit)
//
// One item is taken each cycle while req_ready is high; its result is registered on the way out.
// The frame store is read every cycle at the next play index, so the frame is ready at the tick.
// A skid register holds one extra result, so req_ready is registered and drops only when it is full.
// Reset is synchronous; the frame store is not cleared and needs no clearing pass.
module key_edge_record_replay
   import kerr_pkg::*;
#(
   parameter int unsigned KEY_COUNT   = KEY_COUNT_DEFAULT,
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [KEY_W-1:0] req_keys_down,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [KEY_W-1:0] rsp_pressed,
   output logic [KEY_W-1:0] rsp_pressed_edges,
   output logic [KEY_W-1:0] rsp_released_edges,
   output logic             rsp_playing,
   output logic             rsp_recording,
   output logic [CNT_W-1:0] rsp_frames_stored,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_COUNT >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((32'd1 << KEY_COUNT) - 32'd1);

   logic [CNT_W-1:0] limit_ff;
   logic [KEY_W-1:0] cur_ff, cur_in;
   logic [KEY_W-1:0] prev_ff, prev_in;
   logic [KEY_W-1:0] down_ff, down_in;
   logic [KEY_W-1:0] up_ff, up_in;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] play_idx_ff, play_idx_in;

   logic [KEY_W-1:0] frame_mem [STORE_DEPTH];
   logic [KEY_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   result_type       result;
   result_type       main_ff, main_in;
   result_type       skid_ff, skid_in;
   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             ready_ff, ready_in;
   logic             accept;
   command_type      cmd;

   assign accept    = req_valid && req_ready;
   assign req_ready = ready_ff;
   assign cmd       = command_type'(req_command);

   always_comb begin
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      down_in     = down_ff;
      up_in       = up_ff;
      mode_in     = mode_ff;
      count_in    = count_ff;
      play_idx_in = play_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = ADDR_W'(count_ff);
      if (accept) begin
         case (cmd)
            CMD_TICK: begin
               prev_in = cur_ff;
               if (mode_ff == MODE_PLAY) begin
                  if (play_idx_ff < count_ff) begin
                     cur_in      = rd_data_ff;
                     play_idx_in = play_idx_ff + 1'b1;
                  end else begin
                     cur_in  = '0;
                     mode_in = MODE_NORMAL;
                  end
               end else begin
                  cur_in = req_keys_down & KEY_MASK;
                  if (mode_ff == MODE_RECORD && count_ff < limit_ff &&
                      32'(count_ff) < STORE_DEPTH) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               down_in = (prev_in ^ cur_in) & cur_in;
               up_in   = (prev_in ^ cur_in) & prev_in;
            end
            CMD_RECORD_START: begin
               mode_in  = MODE_RECORD;
               count_in = '0;
            end
            CMD_RECORD_STOP: begin
               mode_in = MODE_NORMAL;
            end
            CMD_PLAY_START: begin
               play_idx_in = '0;
               mode_in     = MODE_PLAY;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   assign rd_addr = ADDR_W'(play_idx_in);

   // The read register always holds the entry at the current play index,
   // including a write to that entry in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= req_keys_down & KEY_MASK;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_data_ff <= req_keys_down & KEY_MASK;
      end else begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_comb begin
      result.pressed        = cur_in;
      result.pressed_edges  = down_in;
      result.released_edges = up_in;
      result.playing        = (mode_in == MODE_PLAY);
      result.recording      = (mode_in == MODE_RECORD);
      result.frames_stored  = count_in;
   end

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
      ready_in = !skid_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= RECORD_LIMIT_RESET;
         cur_ff        <= '0;
         prev_ff       <= '0;
         down_ff       <= '0;
         up_ff         <= '0;
         mode_ff       <= MODE_NORMAL;
         count_ff      <= '0;
         play_idx_ff   <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         ready_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         down_ff       <= down_in;
         up_ff         <= up_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         play_idx_ff   <= play_idx_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
         ready_ff      <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = main_valid_ff;
   assign rsp_pressed        = main_ff.pressed;
   assign rsp_pressed_edges  = main_ff.pressed_edges;
   assign rsp_released_edges = main_ff.released_edges;
   assign rsp_playing        = main_ff.playing;
   assign rsp_recording      = main_ff.recording;
   assign rsp_frames_stored  = main_ff.frames_stored;

`ifndef SYNTHESIS
   // The skid register is filled only behind a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   // Recording never stores more frames than the store holds.
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= STORE_DEPTH)
      else $error("frame count exceeds the store depth");

   // Playback never reads past the recorded frames.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PLAY) |-> (play_idx_ff <= count_ff))
      else $error("play index ran past the stored frames");

   // A start-playback transfer taken while the output register is empty reaches the output in play mode.
   assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_PLAY_START && !main_valid_ff) |=> (rsp_valid && rsp_playing))
      else $error("start playback did not report play mode");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import kerr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      int          new_limit;
      command_type cmd;
      logic [KEY_W-1:0] keys;
      bit          typed;
      result_type  want;
   } plan_entry;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   command_type      req_command = CMD_TICK;
   logic [KEY_W-1:0] req_keys_down = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [KEY_W-1:0] rsp_pressed;
   logic [KEY_W-1:0] rsp_pressed_edges;
   logic [KEY_W-1:0] rsp_released_edges;
   logic             rsp_playing;
   logic             rsp_recording;
   logic [CNT_W-1:0] rsp_frames_stored;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Shadow copy of the key tracker.
   logic [KEY_W-1:0] frame_mem [STORE_DEPTH_DEFAULT];
   logic [KEY_W-1:0] cur_keys = '0;
   logic [KEY_W-1:0] down_keys = '0;
   logic [KEY_W-1:0] up_keys = '0;
   mode_type         tracker_mode = MODE_NORMAL;
   int               frames_held = 0;
   int               replay_pos = 0;
   int               limit_reg = RECORD_LIMIT_RESET;

   result_type pending_reports[$];
   plan_entry  plan[$];

   key_edge_record_replay dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_keys_down      (req_keys_down),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pressed        (rsp_pressed),
      .rsp_pressed_edges  (rsp_pressed_edges),
      .rsp_released_edges (rsp_released_edges),
      .rsp_playing        (rsp_playing),
      .rsp_recording      (rsp_recording),
      .rsp_frames_stored  (rsp_frames_stored),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic result_type step_key_tracker(command_type cmd, logic [KEY_W-1:0] keys);
      logic [KEY_W-1:0] prior;
      int               cap;
      result_type       r;
      cap = (limit_reg < STORE_DEPTH_DEFAULT) ? limit_reg : STORE_DEPTH_DEFAULT;
      case (cmd)
         CMD_TICK: begin
            prior = cur_keys;
            if (tracker_mode == MODE_PLAY) begin
               if (replay_pos < frames_held) begin
                  cur_keys = frame_mem[replay_pos];
                  replay_pos++;
               end else begin
                  cur_keys = '0;
                  tracker_mode = MODE_NORMAL;
               end
            end else begin
               cur_keys = keys;
               if (tracker_mode == MODE_RECORD && frames_held < cap) begin
                  frame_mem[frames_held] = keys;
                  frames_held++;
               end
            end
            down_keys = (prior ^ cur_keys) & cur_keys;
            up_keys = (prior ^ cur_keys) & prior;
         end
         CMD_RECORD_START: begin
            tracker_mode = MODE_RECORD;
            frames_held = 0;
         end
         CMD_RECORD_STOP: begin
            tracker_mode = MODE_NORMAL;
         end
         default: begin
            replay_pos = 0;
            tracker_mode = MODE_PLAY;
         end
      endcase
      r.pressed = cur_keys;
      r.pressed_edges = down_keys;
      r.released_edges = up_keys;
      r.playing = (tracker_mode == MODE_PLAY);
      r.recording = (tracker_mode == MODE_RECORD);
      r.frames_stored = frames_held[CNT_W-1:0];
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_keys();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
         default: return KEY_W'($urandom());
      endcase
   endfunction

   task automatic report_error(input string msg);
      $display("[%0d] %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_report(input result_type got);
      result_type want;
      if (pending_reports.size() == 0) begin
         report_error($sformatf("unexpected transfer on rsp: %h", got));
         return;
      end
      want = pending_reports.pop_front();
      if (got.pressed !== want.pressed)
         report_error($sformatf("pressed: got %h, expected %h", got.pressed, want.pressed));
      if (got.pressed_edges !== want.pressed_edges)
         report_error($sformatf("pressed_edges: got %h, expected %h",
                                got.pressed_edges, want.pressed_edges));
      if (got.released_edges !== want.released_edges)
         report_error($sformatf("released_edges: got %h, expected %h",
                                got.released_edges, want.released_edges));
      if (got.playing !== want.playing)
         report_error($sformatf("playing: got %b, expected %b", got.playing, want.playing));
      if (got.recording !== want.recording)
         report_error($sformatf("recording: got %b, expected %b",
                                got.recording, want.recording));
      if (got.frames_stored !== want.frames_stored)
         report_error($sformatf("frames_stored: got %0d, expected %0d",
                                got.frames_stored, want.frames_stored));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            check_report('{rsp_pressed, rsp_pressed_edges, rsp_released_edges,
                           rsp_playing, rsp_recording, rsp_frames_stored});
         end
      end
   end

   task automatic send_item(input command_type cmd, input logic [KEY_W-1:0] keys,
                            input bit typed = 1'b0, input result_type want = '0);
      result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_keys_down <= keys;
      do @(posedge clock); while (!req_ready);
      predicted = step_key_tracker(cmd, keys);
      pending_reports.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic write_record_limit(input int value);
      drain_reports();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CNT_W-1:0];
      @(posedge clock);
      limit_reg = value & 32'h7FFF;
      csr_wr_en <= 1'b0;
   endtask

   function automatic void plan_row(input int new_limit, input command_type cmd,
                                    input logic [KEY_W-1:0] keys, input bit typed = 1'b0,
                                    input result_type want = '0);
      plan_entry e;
      e.new_limit = new_limit;
      e.cmd = cmd;
      e.keys = keys;
      e.typed = typed;
      e.want = want;
      plan.push_back(e);
   endfunction

   function automatic void build_plan();
      plan_row(-1, CMD_TICK, 16'h0000, 1, '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 15'd0});
      plan_row(-1, CMD_TICK, 16'hFFFF, 1, '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 15'd0});
      plan_row(-1, CMD_TICK, 16'h0000, 1, '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 15'd0});
      // Playback with an empty store holds state, then the next tick clears it.
      plan_row(-1, CMD_PLAY_START, 16'h1234, 1,
               '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 15'd0});
      plan_row(-1, CMD_TICK, 16'h1234, 1, '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 15'd0});
      plan_row(-1, CMD_RECORD_START, 16'hFFFF, 1,
               '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 15'd0});
      plan_row(-1, CMD_TICK, 16'hA5A5, 1, '{16'hA5A5, 16'hA5A5, 16'h0000, 1'b0, 1'b1, 15'd1});
      plan_row(-1, CMD_TICK, 16'h5A5A, 1, '{16'h5A5A, 16'h5A5A, 16'hA5A5, 1'b0, 1'b1, 15'd2});
      plan_row(-1, CMD_TICK, 16'hFFFF, 1, '{16'hFFFF, 16'hA5A5, 16'h0000, 1'b0, 1'b1, 15'd3});
      plan_row(-1, CMD_RECORD_STOP, 16'h0000, 1,
               '{16'hFFFF, 16'hA5A5, 16'h0000, 1'b0, 1'b0, 15'd3});
      plan_row(-1, CMD_PLAY_START, 16'hFFFF, 1,
               '{16'hFFFF, 16'hA5A5, 16'h0000, 1'b1, 1'b0, 15'd3});
      plan_row(-1, CMD_TICK, 16'h0000, 1, '{16'hA5A5, 16'h0000, 16'h5A5A, 1'b1, 1'b0, 15'd3});
      plan_row(-1, CMD_TICK, 16'hFFFF, 1, '{16'h5A5A, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0, 15'd3});
      plan_row(-1, CMD_TICK, 16'h0000);
      plan_row(-1, CMD_TICK, 16'hFFFF);
      plan_row(2, CMD_RECORD_START, 16'h0000);
      plan_row(-1, CMD_TICK, 16'h8001);
      plan_row(-1, CMD_TICK, 16'h7FFE);
      plan_row(-1, CMD_TICK, 16'h0F0F);
      plan_row(-1, CMD_PLAY_START, 16'h0000);
      plan_row(-1, CMD_TICK, 16'hFFFF);
      plan_row(-1, CMD_PLAY_START, 16'h0000);
      plan_row(-1, CMD_TICK, 16'h0000);
      plan_row(-1, CMD_RECORD_START, 16'h0000);
      plan_row(0, CMD_RECORD_START, 16'h0000);
      plan_row(-1, CMD_TICK, 16'hFFFF);
      plan_row(-1, CMD_RECORD_STOP, 16'h0000);
      plan_row(-1, CMD_RECORD_STOP, 16'hFFFF);
      plan_row(-1, CMD_PLAY_START, 16'h0000);
      plan_row(-1, CMD_TICK, 16'h0000);
   endfunction

   task automatic run_phase(input int send_pct, input int recv_pct, input int limit,
                            input int goal);
      int  n;
      int  kind;
      bit  paused;
      write_record_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      items_sent = 0;
      paused = 1'b0;
      while (items_sent < goal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            send_item(CMD_RECORD_START, random_keys());
            n = $urandom_range(0, 24);
            repeat (n) send_item(CMD_TICK, random_keys());
            if ($urandom_range(0, 4) != 0) send_item(CMD_RECORD_STOP, random_keys());
         end else if (kind <= 6) begin
            send_item(CMD_PLAY_START, random_keys());
            n = $urandom_range(0, frames_held + 3);
            if (n > 40) n = 40;
            repeat (n) send_item(CMD_TICK, random_keys());
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 4))
               send_item(command_type'($urandom_range(0, 3)), random_keys());
         end else begin
            repeat ($urandom_range(1, 8)) send_item(CMD_TICK, random_keys());
         end
         if (!paused && items_sent >= goal / 2) begin
            drain_reports();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      build_plan();
      foreach (plan[i]) begin
         if (plan[i].new_limit >= 0) write_record_limit(plan[i].new_limit);
         send_item(plan[i].cmd, plan[i].keys, plan[i].typed, plan[i].want);
      end

      run_phase(31, 77, $urandom_range(1, 16), 220);
      run_phase(77, 31, STORE_DEPTH_DEFAULT, 220);
      run_phase(0, 0, $urandom_range(0, 32767), 220);

      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ key_edge_record_replay.f @@
hw/rtl/kerr_pkg.sv
hw/rtl/key_edge_record_replay.sv
dv/tb.sv
